// ===== rtl/rto_pkg.sv =====
// Shared constants for the rectangle/triangle overlap core.
package rto_pkg;

	localparam int BYTE_W      = 8;
	localparam int NUM_EDGES   = 3;
	localparam int OUT_TDATA_W = BYTE_W;

endpackage

// ===== rtl/rect_triangle_overlap_sat_core.sv =====
// Top level: rectangle/triangle separating-axis overlap pipeline.
//
//  channel  | dir | content
//  s_axis   | in  | rectangle (center, size) and three triangle vertices per word
//  m_axis   | out | one overlap flag per input word
//
// Five-stage pipeline plus output register; a word moves through stages 1 to 5
// into the output register, one word per cycle sustained while m_tready stays high.
// The per-edge multipliers (stage 2) set the clock. arst_n clears all valid bits
// and the output skid slot. A stall on m_tready freezes the whole pipeline once the
// last stage holds a word and the skid slot is full; s_tready depends only on flops.
module rect_triangle_overlap_sat_core import rto_pkg::*; #(
	parameter  int COORD_WIDTH = 20,
	localparam int IN_BITS     = 10 * COORD_WIDTH - 2,
	localparam int IN_TDATA_W  = ((IN_BITS + BYTE_W - 1) / BYTE_W) * BYTE_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// rect_center_x, rect_center_y, rect_width, rect_height,
	// tri_x0, tri_y0, tri_x1, tri_y1, tri_x2, tri_y2, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// overlap, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int W     = COORD_WIDTH;
	localparam int OFF_W = 2 * W;
	localparam int OFF_H = 3 * W - 1;
	localparam int OFF_T = 4 * W - 2;
	localparam int B     = W + 2;   // doubled rectangle bounds

	logic en, skid_rdy, overlap_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [W-1:0] cx_s1, cy_s1;
	logic        [W-2:0] w_s1, h_s1;
	logic signed [W-1:0] tx_s1 [NUM_EDGES];
	logic signed [W-1:0] ty_s1 [NUM_EDGES];
	logic signed [W:0]   nx_s1 [NUM_EDGES];
	logic signed [W:0]   ny_s1 [NUM_EDGES];
	logic signed [B-1:0] xlo_s1, xhi_s1, ylo_s1, yhi_s1;
	logic                wnz_s1, hnz_s1;
	logic signed [B-1:0] tx2 [NUM_EDGES];
	logic signed [B-1:0] ty2 [NUM_EDGES];
	logic                sep01_s2, sep01_s3, sep01_s4, sep01_s5;
	logic [NUM_EDGES-1:0] sep_e;
	logic signed [W-1:0] in_tx [NUM_EDGES];
	logic signed [W-1:0] in_ty [NUM_EDGES];
	logic signed [W-1:0] in_cx, in_cy;
	logic        [W-2:0] in_w, in_h;

	assign en       = ~v_s5 | skid_rdy;
	assign s_tready = en;

	assign in_cx = s_tdata[W-1:0];
	assign in_cy = s_tdata[2*W-1:W];
	assign in_w  = s_tdata[OFF_W +: W-1];
	assign in_h  = s_tdata[OFF_H +: W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_EDGES; gi++) begin : g_edge
			localparam int GJ = (gi + 1) % NUM_EDGES;
			localparam int GK = (gi + 2) % NUM_EDGES;

			assign in_tx[gi] = s_tdata[OFF_T + 2*gi*W +: W];
			assign in_ty[gi] = s_tdata[OFF_T + (2*gi+1)*W +: W];
			assign tx2[gi]   = {tx_s1[gi][W-1], tx_s1[gi], 1'b0};
			assign ty2[gi]   = {ty_s1[gi][W-1], ty_s1[gi], 1'b0};

			// stage 1: vertices and edge normal (-dy, dx)
			always_ff @(posedge clk) begin
				if (en) begin
					tx_s1[gi] <= in_tx[gi];
					ty_s1[gi] <= in_ty[gi];
					nx_s1[gi] <= {in_ty[gi][W-1], in_ty[gi]} - {in_ty[GJ][W-1], in_ty[GJ]};
					ny_s1[gi] <= {in_tx[GJ][W-1], in_tx[GJ]} - {in_tx[gi][W-1], in_tx[gi]};
				end
			end

			rto_axis_proj #(
				.COORD_WIDTH(COORD_WIDTH)
			) u_proj (
				.clk (clk),
				.en  (en),
				.xi  (tx_s1[gi]),
				.yi  (ty_s1[gi]),
				.xk  (tx_s1[GK]),
				.yk  (ty_s1[GK]),
				.cx  (cx_s1),
				.cy  (cy_s1),
				.w   (w_s1),
				.h   (h_s1),
				.nx  (nx_s1[gi]),
				.ny  (ny_s1[gi]),
				.sep (sep_e[gi])
			);
		end
	endgenerate

	// stage 1: rectangle bounds in doubled units
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1  <= in_cx;
			cy_s1  <= in_cy;
			w_s1   <= in_w;
			h_s1   <= in_h;
			xlo_s1 <= {in_cx[W-1], in_cx, 1'b0} - {3'b000, in_w};
			xhi_s1 <= {in_cx[W-1], in_cx, 1'b0} + {3'b000, in_w};
			ylo_s1 <= {in_cy[W-1], in_cy, 1'b0} - {3'b000, in_h};
			yhi_s1 <= {in_cy[W-1], in_cy, 1'b0} + {3'b000, in_h};
			wnz_s1 <= |in_w;
			hnz_s1 <= |in_h;
		end
	end

	// rectangle axes: a zero size gives a zero axis, which never separates
	always_ff @(posedge clk) begin
		if (en) begin
			sep01_s2 <= (wnz_s1 &&
				((yhi_s1 < ty2[0] && yhi_s1 < ty2[1] && yhi_s1 < ty2[2]) ||
				 (ty2[0] < ylo_s1 && ty2[1] < ylo_s1 && ty2[2] < ylo_s1))) ||
				(hnz_s1 &&
				((xhi_s1 < tx2[0] && xhi_s1 < tx2[1] && xhi_s1 < tx2[2]) ||
				 (tx2[0] < xlo_s1 && tx2[1] < xlo_s1 && tx2[2] < xlo_s1)));
			sep01_s3 <= sep01_s2;
			sep01_s4 <= sep01_s3;
			sep01_s5 <= sep01_s4;
		end
	end

	assign overlap_s5 = ~(sep01_s5 | (|sep_e));

	rto_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.in_ready (skid_rdy),
		.in_data  ({{(OUT_TDATA_W-1){1'b0}}, overlap_s5}),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s5)
		else $error("pipeline stalled without a word in the last stage");

	a_handoff_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && s_tready) |=> m_tvalid)
		else $error("word left the pipeline but no output is valid");

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_rdy |-> m_tvalid)
		else $error("skid slot full while output register empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted word missing from stage 1");

endmodule

// ===== rtl/rto_axis_proj.sv =====
// Projection and interval test of both shapes on one triangle edge normal (stages 2 to 5).
module rto_axis_proj import rto_pkg::*; #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] xi,
	input  logic signed [COORD_WIDTH-1:0] yi,
	input  logic signed [COORD_WIDTH-1:0] xk,
	input  logic signed [COORD_WIDTH-1:0] yk,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic        [COORD_WIDTH-2:0] w,
	input  logic        [COORD_WIDTH-2:0] h,
	input  logic signed [COORD_WIDTH:0]   nx,
	input  logic signed [COORD_WIDTH:0]   ny,
	output logic                          sep
);

	localparam int W = COORD_WIDTH;
	localparam int P = 2 * W + 1;   // product
	localparam int S = 2 * W + 2;   // sum of two products
	localparam int E = 2 * W;       // rectangle half extent, doubled units
	localparam int D = 2 * W + 4;   // doubled projections

	function automatic logic signed [P-1:0] sx_c(input logic signed [W-1:0] v);
		return {{(P-W){v[W-1]}}, v};
	endfunction

	function automatic logic signed [P-1:0] sx_n(input logic signed [W:0] v);
		return {{(P-W-1){v[W]}}, v};
	endfunction

	function automatic logic signed [P-1:0] zx_s(input logic [W-2:0] v);
		return {{(P-W+1){1'b0}}, v};
	endfunction

	function automatic logic [E-1:0] mag(input logic signed [P-1:0] v);
		logic signed [P-1:0] a;
		a = v[P-1] ? -v : v;
		return a[E-1:0];
	endfunction

	logic signed [P-1:0] pix_s2, piy_s2, pkx_s2, pky_s2, pcx_s2, pcy_s2, ew_s2, eh_s2;
	logic signed [S-1:0] pi_s3, pk_s3, pc_s3;
	logic        [E-1:0] e_s3;
	logic signed [D-1:0] tmin_s4, tmax_s4, rlo_s4, rhi_s4;
	logic signed [S-1:0] lo_sel, hi_sel;

	// stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2 <= sx_c(xi) * sx_n(nx);
			piy_s2 <= sx_c(yi) * sx_n(ny);
			pkx_s2 <= sx_c(xk) * sx_n(nx);
			pky_s2 <= sx_c(yk) * sx_n(ny);
			pcx_s2 <= sx_c(cx) * sx_n(nx);
			pcy_s2 <= sx_c(cy) * sx_n(ny);
			ew_s2  <= zx_s(w) * sx_n(nx);
			eh_s2  <= zx_s(h) * sx_n(ny);
		end
	end

	// stage 3: dot products, rectangle extent w*|nx| + h*|ny|
	always_ff @(posedge clk) begin
		if (en) begin
			pi_s3 <= {pix_s2[P-1], pix_s2} + {piy_s2[P-1], piy_s2};
			pk_s3 <= {pkx_s2[P-1], pkx_s2} + {pky_s2[P-1], pky_s2};
			pc_s3 <= {pcx_s2[P-1], pcx_s2} + {pcy_s2[P-1], pcy_s2};
			e_s3  <= mag(ew_s2) + mag(eh_s2);
		end
	end

	// vertex i and its edge partner project equally, so two points bound the triangle
	assign lo_sel = (pi_s3 < pk_s3) ? pi_s3 : pk_s3;
	assign hi_sel = (pi_s3 < pk_s3) ? pk_s3 : pi_s3;

	// stage 4: intervals in doubled units
	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s4 <= {lo_sel[S-1], lo_sel, 1'b0};
			tmax_s4 <= {hi_sel[S-1], hi_sel, 1'b0};
			rlo_s4  <= {pc_s3[S-1], pc_s3, 1'b0} - {{(D-E){1'b0}}, e_s3};
			rhi_s4  <= {pc_s3[S-1], pc_s3, 1'b0} + {{(D-E){1'b0}}, e_s3};
		end
	end

	// stage 5: strict gap on either side; touching counts as overlap
	always_ff @(posedge clk) begin
		if (en) begin
			sep <= (rhi_s4 < tmin_s4) || (tmax_s4 < rlo_s4);
		end
	end

endmodule

// ===== rtl/rto_skid.sv =====
// Output register with a skid slot, so the upstream ready comes from flops only.
module rto_skid import rto_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [OUT_TDATA_W-1:0] in_data,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic                   out_v_q, skid_v_q;
	logic [OUT_TDATA_W-1:0] out_q, skid_q;

	assign in_ready = ~skid_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= in_valid;
				end
			end else if (!out_v_q) begin
				out_v_q <= in_valid;
			end else if (in_valid && !skid_v_q) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && m_tready) begin
			out_q <= skid_v_q ? skid_q : in_data;
		end else if (!out_v_q) begin
			out_q <= in_data;
		end
		if (in_valid && !skid_v_q && out_v_q && !m_tready) begin
			skid_q <= in_data;
		end
	end

endmodule
